// ----- rtl/core/cmdfr_pkg.sv -----
// shared types, constants and register codes of the command frame receiver
package cmdfr_pkg;

    localparam int FRAME_LENGTH = 14;
    localparam int COUNT_W      = 4;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

    // only the leading bytes up to and including the sequence number are checked
    localparam int STORED_BYTES = 10;
    localparam int BYTE_IDX_W   = $clog2(STORED_BYTES);

    localparam int POS_MAGIC_HI = 0;
    localparam int POS_MAGIC_LO = 1;
    localparam int POS_VERSION  = 2;
    localparam int POS_MODE     = 3;
    localparam int POS_ANGLE_HI = 4;
    localparam int POS_ANGLE_LO = 5;
    localparam int POS_MAG      = 6;
    localparam int POS_PAD      = 7;
    localparam int POS_SEQ_HI   = 8;
    localparam int POS_SEQ_LO   = 9;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic MODE_BYTE     = 1'b0;
    localparam logic MODE_CHECK    = 1'b1;
    localparam logic KIND_VERDICT  = 1'b0;
    localparam logic KIND_TIMEOUT  = 1'b1;
    localparam logic CMD_STOP      = 1'b0;
    localparam logic CMD_DRIVE     = 1'b1;
    localparam logic [7:0] PAD_VALUE = 8'd0;

    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        CFG_FRAME_MAGIC     = 3'd0,
        CFG_FRAME_VERSION   = 3'd1,
        CFG_ANGLE_LOWER     = 3'd2,
        CFG_ANGLE_UPPER     = 3'd3,
        CFG_MAGNITUDE_LOWER = 3'd4,
        CFG_MAGNITUDE_UPPER = 3'd5,
        CFG_SEQUENCE_WINDOW = 3'd6,
        CFG_LINK_TIMEOUT    = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [15:0]        frame_magic;
        logic [7:0]         frame_version;
        logic signed [15:0] angle_lower_limit;
        logic signed [15:0] angle_upper_limit;
        logic [7:0]         magnitude_lower_limit;
        logic [7:0]         magnitude_upper_limit;
        logic [15:0]        sequence_window;
        logic [31:0]        link_timeout_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        frame_magic:           16'd0,
        frame_version:         8'd1,
        angle_lower_limit:     -16'sd180,
        angle_upper_limit:     16'sd180,
        magnitude_lower_limit: 8'd0,
        magnitude_upper_limit: 8'd100,
        sequence_window:       16'd32767,
        link_timeout_ms:       32'd500
    };

    typedef struct packed {
        logic        mode;
        logic [7:0]  wire_byte;
        logic        end_of_datagram;
        logic [31:0] now_ms;
    } rx_item_t;

    typedef struct packed {
        logic               result_kind;
        logic               accepted;
        logic               command_mode;
        logic signed [15:0] steer_angle;
        logic [7:0]         drive_level;
        logic               timed_out;
    } res_item_t;

    // classified work passed from the front to the back
    typedef struct packed {
        logic               kind;
        logic               frame_ok;
        logic               cmd;
        logic signed [15:0] angle;
        logic [7:0]         mag;
        logic [15:0]        seq;
        logic [31:0]        now_ms;
    } entry_t;

endpackage

// ----- rtl/core/cmdfr_front.sv -----
// front end: collects datagram bytes and classifies finished frames and time checks
module cmdfr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  cmdfr_pkg::cfg_t     cfg,
    input  logic               rx_valid,
    input  cmdfr_pkg::rx_item_t rx_item,
    output logic               rx_stall,
    input  logic               q_full,
    output logic               q_push,
    output cmdfr_pkg::entry_t   q_entry
);
    import cmdfr_pkg::*;

    logic [COUNT_W-1:0] byte_count_reg;
    logic [COUNT_W-1:0] byte_count_next;
    logic [7:0]         bytes_reg [STORED_BYTES];
    logic               take;
    logic               store;
    logic               len_ok;
    logic               header_ok;
    logic               limits_ok;
    logic               cmd;
    logic signed [15:0] angle;
    logic [7:0]         mag;

    assign rx_stall = q_full;
    assign take     = rx_valid && !q_full;
    assign store    = take && (rx_item.mode == MODE_BYTE) &&
                      (byte_count_reg < COUNT_W'(STORED_BYTES));

    // the final byte completes a full frame when exactly one byte is still missing
    assign len_ok = (byte_count_reg == COUNT_W'(FRAME_LENGTH - 1));

    assign cmd   = bytes_reg[POS_MODE][0];
    assign angle = $signed({bytes_reg[POS_ANGLE_HI], bytes_reg[POS_ANGLE_LO]});
    assign mag   = bytes_reg[POS_MAG];

    assign header_ok = ({bytes_reg[POS_MAGIC_HI], bytes_reg[POS_MAGIC_LO]} == cfg.frame_magic)
                    && (bytes_reg[POS_VERSION] == cfg.frame_version)
                    && (bytes_reg[POS_PAD] == PAD_VALUE)
                    && (bytes_reg[POS_MODE][7:1] == 7'd0);

    assign limits_ok = (cmd == CMD_STOP) ||
                       (angle >= $signed(cfg.angle_lower_limit) &&
                        angle <= $signed(cfg.angle_upper_limit) &&
                        mag >= cfg.magnitude_lower_limit &&
                        mag <= cfg.magnitude_upper_limit);

    always_comb
    begin
        q_push          = 1'b0;
        q_entry         = '0;
        q_entry.now_ms  = rx_item.now_ms;
        byte_count_next = byte_count_reg;
        if (take)
        begin
            if (rx_item.mode == MODE_CHECK)
            begin
                q_push       = 1'b1;
                q_entry.kind = KIND_TIMEOUT;
            end
            else if (rx_item.end_of_datagram)
            begin
                q_push           = 1'b1;
                q_entry.kind     = KIND_VERDICT;
                q_entry.frame_ok = len_ok && header_ok && limits_ok;
                q_entry.cmd      = cmd;
                q_entry.angle    = (cmd == CMD_DRIVE) ? angle : 16'sd0;
                q_entry.mag      = (cmd == CMD_DRIVE) ? mag : 8'd0;
                q_entry.seq      = {bytes_reg[POS_SEQ_HI], bytes_reg[POS_SEQ_LO]};
                byte_count_next  = '0;
            end
            else if (byte_count_reg != COUNT_MAX)
            begin
                byte_count_next = byte_count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            bytes_reg[byte_count_reg[BYTE_IDX_W-1:0]] <= rx_item.wire_byte;
        end
    end

endmodule

// ----- rtl/core/cmdfr_queue.sv -----
// short in-order queue between the front and the back
module cmdfr_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cmdfr_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output cmdfr_pkg::entry_t head
);
    import cmdfr_pkg::*;

    entry_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = entries_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- rtl/core/cmdfr_back.sv -----
// back end: sequence window, link time bookkeeping and the result register
module cmdfr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  cmdfr_pkg::cfg_t     cfg,
    input  logic               q_valid,
    input  cmdfr_pkg::entry_t   q_head,
    output logic               q_pop,
    output logic               res_valid,
    input  logic               res_stall,
    output cmdfr_pkg::res_item_t res_item
);
    import cmdfr_pkg::*;

    logic        held_reg;
    logic        held_next;
    logic [15:0] last_seq_reg;
    logic [15:0] last_seq_next;
    logic [31:0] last_time_reg;
    logic [31:0] last_time_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    res_item_t   out_item_reg;
    res_item_t   out_item_next;
    logic [15:0] seq_delta;
    logic [31:0] elapsed;
    logic        seq_ok;

    // the result register frees up in the same cycle it is taken
    assign q_pop     = q_valid && (!out_valid_reg || !res_stall);
    assign seq_delta = q_head.seq - last_seq_reg;
    assign elapsed   = q_head.now_ms - last_time_reg;
    assign seq_ok    = !held_reg || (seq_delta != 16'd0 && seq_delta <= cfg.sequence_window);

    always_comb
    begin
        held_next      = held_reg;
        last_seq_next  = last_seq_reg;
        last_time_next = last_time_reg;
        out_valid_next = out_valid_reg && res_stall;
        out_item_next  = out_item_reg;
        if (q_pop)
        begin
            out_valid_next = 1'b1;
            out_item_next  = '0;
            if (q_head.kind == KIND_TIMEOUT)
            begin
                out_item_next.result_kind = KIND_TIMEOUT;
                out_item_next.timed_out   = held_reg && (elapsed > cfg.link_timeout_ms);
            end
            else if (q_head.frame_ok && seq_ok)
            begin
                out_item_next.result_kind  = KIND_VERDICT;
                out_item_next.accepted     = 1'b1;
                out_item_next.command_mode = q_head.cmd;
                out_item_next.steer_angle  = q_head.angle;
                out_item_next.drive_level  = q_head.mag;
                held_next      = 1'b1;
                last_seq_next  = q_head.seq;
                last_time_next = q_head.now_ms;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= 1'b0;
            last_seq_reg  <= '0;
            last_time_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg      <= held_next;
            last_seq_reg  <= last_seq_next;
            last_time_reg <= last_time_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign res_valid = out_valid_reg;
    assign res_item  = out_item_reg;

endmodule

// ----- rtl/core/command_frame_receiver.sv -----
// command frame receiver top level: configuration registers, front, queue and back
//
// rx channel: one item per handshake, either a datagram byte (mode 0, the last
// byte of a datagram flagged by end_of_datagram) or a link time check (mode 1)
// carrying the current time in ms. res channel: one verdict per datagram and
// one timeout status per time check; bytes that do not end a datagram give none.
// An item is taken on a clock edge with valid high and stall low.
// Throughput is one item per cycle while rx_stall is low: the front classifies a
// frame in the cycle its final byte arrives, and the back settles the sequence
// window and the link timer as it pops each queued entry.
// A taken item is written into the queue; the back pops it and registers its
// result in the output register, which drives res_valid.
// A stalled result holds the output register; the two-entry queue then fills
// and rx_stall rises while the queue is full.
// Configuration: cfg_write with cfg_index and cfg_data, one register per edge,
// while no item is in flight. Reset restores the register defaults, clears
// the byte count, the held sequence flag, sequence and link time, and empties
// the queue and output register.
module command_frame_receiver (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  cmdfr_pkg::cfg_index_t    cfg_index,
    input  logic [cmdfr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                    rx_valid,
    output logic                    rx_stall,
    input  cmdfr_pkg::rx_item_t      rx_item,
    output logic                    res_valid,
    input  logic                    res_stall,
    output cmdfr_pkg::res_item_t     res_item
);
    import cmdfr_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_valid;
    entry_t q_in;
    entry_t q_head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_FRAME_MAGIC:     cfg_next.frame_magic           = cfg_data[15:0];
                CFG_FRAME_VERSION:   cfg_next.frame_version         = cfg_data[7:0];
                CFG_ANGLE_LOWER:     cfg_next.angle_lower_limit     = $signed(cfg_data[15:0]);
                CFG_ANGLE_UPPER:     cfg_next.angle_upper_limit     = $signed(cfg_data[15:0]);
                CFG_MAGNITUDE_LOWER: cfg_next.magnitude_lower_limit = cfg_data[7:0];
                CFG_MAGNITUDE_UPPER: cfg_next.magnitude_upper_limit = cfg_data[7:0];
                CFG_SEQUENCE_WINDOW: cfg_next.sequence_window       = cfg_data[15:0];
                CFG_LINK_TIMEOUT:    cfg_next.link_timeout_ms       = cfg_data[31:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cmdfr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .rx_valid (rx_valid),
        .rx_item  (rx_item),
        .rx_stall (rx_stall),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    cmdfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (q_head)
    );

    cmdfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    // a new result only ever comes out of a queue entry
    a_result_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(q_pop))
        else $error("result appeared without a queue entry");

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("push into full queue");

    // an accepted frame is a verdict and never flags a timeout
    a_accept_is_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_item.accepted) |->
            (res_item.result_kind == KIND_VERDICT && !res_item.timed_out))
        else $error("accepted result with wrong kind or timeout");

    // a timeout status carries no command
    a_timeout_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_item.result_kind == KIND_TIMEOUT) |->
            (!res_item.accepted && res_item.steer_angle == 16'sd0 &&
             res_item.drive_level == 8'd0 && res_item.command_mode == CMD_STOP))
        else $error("timeout status carries command fields");

endmodule
